[hdl/tnpd_pkg.sv]
// Shared types, register codes and constants for the two-nearest palette mapper.
`default_nettype none

package tnpd_pkg;

    // Fixed field widths.
    localparam int COMP_W  = 8;
    localparam int COLOR_W = 3 * COMP_W;
    localparam int IN_IDX_W = 5;
    localparam int OUT_IDX_W = 5;
    localparam int DIST_W  = 19;
    localparam int FRAC_W  = 9;
    localparam int PHASES_MAX = 4;

    // Divider widths: numerator times 256 and the shifted divisor.
    localparam int NUM_W = 19;
    localparam int DEN_W = 18;
    localparam int REM_W = 27;
    localparam int DIV_STEPS = 9;

    // Configuration register codes (word index on the APB port).
    localparam logic [1:0] CFG_ACTIVE_COLORS = 2'd0;
    localparam logic [1:0] CFG_PHASE_COUNT   = 2'd1;
    localparam logic [1:0] CFG_DEADBAND      = 2'd2;

    // Register reset values.
    localparam logic [5:0]  ACTIVE_RESET   = 6'd16;
    localparam logic [2:0]  PHASES_RESET   = 3'd1;
    localparam logic [18:0] DEADBAND_RESET = 19'd512;

    // Phase thresholds (2p+1)*256/(2*phases), row by phase count minus one.
    localparam logic [FRAC_W-1:0] PHASE_THR [PHASES_MAX][PHASES_MAX] = '{
        '{9'd128, 9'd0,   9'd0,   9'd0},
        '{9'd64,  9'd192, 9'd0,   9'd0},
        '{9'd42,  9'd128, 9'd213, 9'd0},
        '{9'd32,  9'd96,  9'd160, 9'd224}
    };

    typedef struct packed {
        logic [5:0]  active_colors;
        logic [2:0]  phase_count;
        logic [18:0] deadband;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_DIFF,
        ST_PROD,
        ST_SUM,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_NEAR,
        RD_SECOND
    } rd_sel_t;

    typedef struct packed {
        logic    write_entry;
        logic    take_query;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_a;
        logic    cap_diff;
        logic    cap_prod;
        logic    cap_sum;
        logic    div_step;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic solid;
    } stat_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] nearest;
        logic [OUT_IDX_W-1:0] second;
        logic                 has_second;
        logic                 solid;
        logic [FRAC_W-1:0]    fraction;
        logic [OUT_IDX_W-1:0] phase_zero;
        logic [OUT_IDX_W-1:0] phase_one;
        logic [OUT_IDX_W-1:0] phase_two;
        logic [OUT_IDX_W-1:0] phase_three;
    } res_t;

endpackage

`default_nettype wire

[hdl/tnpd_if.sv]
// Valid/ready channel interfaces for palette words in and mapping words out.
`default_nettype none

interface tnpd_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [4:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, op, entry_index, red, green, blue, input ready);
    modport sink   (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface tnpd_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] nearest;
    logic [4:0] second;
    logic       has_second;
    logic       solid;
    logic [8:0] fraction;
    logic [4:0] phase_zero;
    logic [4:0] phase_one;
    logic [4:0] phase_two;
    logic [4:0] phase_three;

    modport source (output valid, nearest, second, has_second, solid, fraction,
                    phase_zero, phase_one, phase_two, phase_three, input ready);
    modport sink   (input valid, nearest, second, has_second, solid, fraction,
                    phase_zero, phase_one, phase_two, phase_three, output ready);
endinterface

`default_nettype wire

[hdl/tnpd_cfg_regs.sv]
// APB configuration registers: active entry count, phase count and deadband.
`default_nettype none

module tnpd_cfg_regs
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output      logic [31:0]         prdata,
    output      logic                pready,
    output      tnpd_pkg::cfg_t      cfg
);

    tnpd_pkg::cfg_t cfg_reg;
    tnpd_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write decode; an address beyond the list is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                tnpd_pkg::CFG_ACTIVE_COLORS: cfg_next.active_colors = pwdata[5:0];
                tnpd_pkg::CFG_PHASE_COUNT:   cfg_next.phase_count   = pwdata[2:0];
                tnpd_pkg::CFG_DEADBAND:      cfg_next.deadband      = pwdata[18:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_colors <= tnpd_pkg::ACTIVE_RESET;
            cfg_reg.phase_count   <= tnpd_pkg::PHASES_RESET;
            cfg_reg.deadband      <= tnpd_pkg::DEADBAND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back.
    always_comb
    begin
        case (paddr[3:2])
            tnpd_pkg::CFG_ACTIVE_COLORS: prdata = {26'd0, cfg_reg.active_colors};
            tnpd_pkg::CFG_PHASE_COUNT:   prdata = {29'd0, cfg_reg.phase_count};
            tnpd_pkg::CFG_DEADBAND:      prdata = {13'd0, cfg_reg.deadband};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/tnpd_ctrl.sv]
// Sequencer: palette scan, operand fetch, projection and divide steps, output hand-off.
`default_nettype none

module tnpd_ctrl #(
    parameter int MAX_COLORS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_op,
    input  wire logic                   out_ready,
    input  wire logic [5:0]             active_colors,
    input  wire tnpd_pkg::stat_t        stat,
    output      tnpd_pkg::cmd_t         cmd,
    output      logic [$clog2(MAX_COLORS)-1:0] scan_addr,
    output      logic                   in_ready,
    output      logic                   out_valid
);

    localparam int IDX_W = $clog2(MAX_COLORS);
    localparam int CNT_W = $clog2(MAX_COLORS + 1);

    tnpd_pkg::state_t state_reg;
    tnpd_pkg::state_t state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [3:0]       div_cnt_reg;
    logic [3:0]       div_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [8:0]       n_wide;
    logic [CNT_W-1:0] n_last;
    logic             accept;
    logic             out_free;

    // Entry count, with zero taken as one and saturation at the store depth.
    always_comb
    begin
        if (active_colors == 6'd0)
        begin
            n_wide = 9'd1;
        end
        else if (9'(active_colors) > 9'(MAX_COLORS))
        begin
            n_wide = 9'(MAX_COLORS);
        end
        else
        begin
            n_wide = 9'(active_colors);
        end
    end

    assign n_last    = CNT_W'(n_wide - 9'd1);
    assign in_ready  = (state_reg == tnpd_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign scan_addr = cnt_reg[IDX_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tnpd_pkg::ST_IDLE:
            begin
                if (accept && in_op)
                begin
                    state_next = tnpd_pkg::ST_SCAN;
                end
            end
            tnpd_pkg::ST_SCAN:
            begin
                if (cnt_reg == n_last)
                begin
                    state_next = tnpd_pkg::ST_DRAIN;
                end
            end
            tnpd_pkg::ST_DRAIN:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = stat.solid ? tnpd_pkg::ST_FINISH : tnpd_pkg::ST_FETCH_A;
                end
            end
            tnpd_pkg::ST_FETCH_A: state_next = tnpd_pkg::ST_FETCH_B;
            tnpd_pkg::ST_FETCH_B: state_next = tnpd_pkg::ST_DIFF;
            tnpd_pkg::ST_DIFF:    state_next = tnpd_pkg::ST_PROD;
            tnpd_pkg::ST_PROD:    state_next = tnpd_pkg::ST_SUM;
            tnpd_pkg::ST_SUM:     state_next = tnpd_pkg::ST_DIV;
            tnpd_pkg::ST_DIV:
            begin
                if (div_cnt_reg == 4'(tnpd_pkg::DIV_STEPS - 1))
                begin
                    state_next = tnpd_pkg::ST_FINISH;
                end
            end
            tnpd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = tnpd_pkg::ST_IDLE;
                end
            end
            default: state_next = tnpd_pkg::ST_IDLE;
        endcase
    end

    // Commands and counters.
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = tnpd_pkg::RD_SCAN;
        cnt_next       = cnt_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            tnpd_pkg::ST_IDLE:
            begin
                cmd.write_entry = accept && !in_op;
                cmd.take_query  = accept && in_op;
                cnt_next        = '0;
            end
            tnpd_pkg::ST_SCAN:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tnpd_pkg::RD_SCAN;
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            tnpd_pkg::ST_FETCH_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tnpd_pkg::RD_NEAR;
            end
            tnpd_pkg::ST_FETCH_B:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tnpd_pkg::RD_SECOND;
                cmd.cap_a  = 1'b1;
            end
            tnpd_pkg::ST_DIFF: cmd.cap_diff = 1'b1;
            tnpd_pkg::ST_PROD: cmd.cap_prod = 1'b1;
            tnpd_pkg::ST_SUM:
            begin
                cmd.cap_sum  = 1'b1;
                div_cnt_next = 4'd0;
            end
            tnpd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 4'd1;
            end
            tnpd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tnpd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            div_cnt_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[hdl/tnpd_datapath.sv]
// Palette memory, distance pipeline, two-best tracker, projection and restoring divider.
`default_nettype none

module tnpd_datapath #(
    parameter int MAX_COLORS = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tnpd_pkg::cmd_t                cmd,
    input  wire logic [$clog2(MAX_COLORS)-1:0] scan_addr,
    input  wire logic [4:0]                    entry_index,
    input  wire logic [7:0]                    red,
    input  wire logic [7:0]                    green,
    input  wire logic [7:0]                    blue,
    input  wire tnpd_pkg::cfg_t                cfg,
    output      tnpd_pkg::stat_t               stat,
    output      tnpd_pkg::res_t                res
);

    localparam int IDX_W = $clog2(MAX_COLORS);
    localparam int CW    = tnpd_pkg::COMP_W;

    // Palette store and its registered read port.
    logic [tnpd_pkg::COLOR_W-1:0] mem [MAX_COLORS];
    logic [tnpd_pkg::COLOR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]             rd_addr;
    logic                         wr_ok;

    logic [tnpd_pkg::COLOR_W-1:0] col_reg;
    logic [tnpd_pkg::COLOR_W-1:0] a_reg;

    // Scan pipeline.
    logic                         s1_vld_reg;
    logic [IDX_W-1:0]             s1_idx_reg;
    logic                         s2_vld_reg;
    logic [IDX_W-1:0]             s2_idx_reg;
    logic [15:0]                  sq_reg [3];
    logic signed [CW:0]           dq [3];
    logic signed [2*CW+1:0]       sq_prod [3];
    logic [tnpd_pkg::DIST_W-1:0]  dist_c;

    // Two best entries.
    logic [IDX_W-1:0]             i0_reg;
    logic [IDX_W-1:0]             i1_reg;
    logic [tnpd_pkg::DIST_W-1:0]  d0_reg;
    logic [tnpd_pkg::DIST_W-1:0]  d1_reg;
    logic                         have1_reg;

    // Projection and divider.
    logic signed [CW:0]           ea_c [3];
    logic signed [CW:0]           eb_c [3];
    logic signed [CW:0]           ea_reg [3];
    logic signed [CW:0]           eb_reg [3];
    logic signed [2*CW+1:0]       pn_reg [3];
    logic signed [2*CW+1:0]       pd_reg [3];
    logic signed [tnpd_pkg::NUM_W-1:0] num_c;
    logic [tnpd_pkg::DEN_W-1:0]   den_c;
    logic                         num_pos_c;
    logic                         num_pos_reg;
    logic                         sat_reg;
    logic [tnpd_pkg::REM_W-1:0]   rem_reg;
    logic [tnpd_pkg::REM_W-1:0]   dsh_reg;
    logic [tnpd_pkg::FRAC_W-1:0]  q_reg;
    logic [tnpd_pkg::FRAC_W-1:0]  t_c;

    logic [2:0]                   nph;
    logic [1:0]                   nph_row;
    logic                         solid_c;
    logic [IDX_W-1:0]             ph_c [tnpd_pkg::PHASES_MAX];

    assign wr_ok = (9'(entry_index) < 9'(MAX_COLORS));

    always_comb
    begin
        case (cmd.rd_sel)
            tnpd_pkg::RD_SCAN:   rd_addr = scan_addr;
            tnpd_pkg::RD_NEAR:   rd_addr = i0_reg;
            tnpd_pkg::RD_SECOND: rd_addr = i1_reg;
            default:             rd_addr = scan_addr;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && wr_ok)
        begin
            mem[IDX_W'(entry_index)] <= {red, green, blue};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Query colour and operand capture.
    always_ff @(posedge clk)
    begin
        if (cmd.take_query)
        begin
            col_reg <= {red, green, blue};
        end
        if (cmd.cap_a)
        begin
            a_reg <= rd_data_reg;
        end
    end

    // Stage valid bits for the scan pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.rd_en && (cmd.rd_sel == tnpd_pkg::RD_SCAN);
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Per-channel differences and squares of the entry just read.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dq[k] = $signed({1'b0, col_reg[(2-k)*CW +: CW]})
                  - $signed({1'b0, rd_data_reg[(2-k)*CW +: CW]});
            sq_prod[k] = dq[k] * dq[k];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= rd_addr;
        s2_idx_reg <= s1_idx_reg;
        for (int k = 0; k < 3; k++)
        begin
            sq_reg[k] <= sq_prod[k][15:0];
        end
    end

    // Weighted distance 2*r^2 + 5*g^2 + b^2.
    assign dist_c = (tnpd_pkg::DIST_W'(sq_reg[0]) << 1)
                  + (tnpd_pkg::DIST_W'(sq_reg[1]) << 2)
                  + tnpd_pkg::DIST_W'(sq_reg[1])
                  + tnpd_pkg::DIST_W'(sq_reg[2]);

    // Nearest and second nearest; a tie keeps the lower index.
    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            if (s2_idx_reg == '0)
            begin
                d0_reg    <= dist_c;
                i0_reg    <= '0;
                i1_reg    <= '0;
                have1_reg <= 1'b0;
            end
            else if (dist_c < d0_reg)
            begin
                i1_reg    <= i0_reg;
                d1_reg    <= d0_reg;
                have1_reg <= 1'b1;
                i0_reg    <= s2_idx_reg;
                d0_reg    <= dist_c;
            end
            else if (!have1_reg || (dist_c < d1_reg))
            begin
                i1_reg    <= s2_idx_reg;
                d1_reg    <= dist_c;
                have1_reg <= 1'b1;
            end
        end
    end

    // Effective phase count and the solid decision.
    always_comb
    begin
        if (cfg.phase_count == 3'd0)
        begin
            nph = 3'd1;
        end
        else if (cfg.phase_count > 3'(tnpd_pkg::PHASES_MAX))
        begin
            nph = 3'(tnpd_pkg::PHASES_MAX);
        end
        else
        begin
            nph = cfg.phase_count;
        end
    end

    assign nph_row = 2'(nph - 3'd1);
    assign solid_c = (nph == 3'd1) || !have1_reg || (d0_reg <= cfg.deadband);

    assign stat.scan_busy = s1_vld_reg || s2_vld_reg;
    assign stat.solid     = solid_c;

    // Offsets of the query and of the second entry from the nearest entry.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ea_c[k] = $signed({1'b0, col_reg[(2-k)*CW +: CW]})
                    - $signed({1'b0, a_reg[(2-k)*CW +: CW]});
            eb_c[k] = $signed({1'b0, rd_data_reg[(2-k)*CW +: CW]})
                    - $signed({1'b0, a_reg[(2-k)*CW +: CW]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.cap_diff)
            begin
                ea_reg[k] <= ea_c[k];
                eb_reg[k] <= eb_c[k];
            end
            if (cmd.cap_prod)
            begin
                pn_reg[k] <= ea_reg[k] * eb_reg[k];
                pd_reg[k] <= eb_reg[k] * eb_reg[k];
            end
        end
    end

    // Dot product and squared length, then the divider set-up.
    assign num_c = tnpd_pkg::NUM_W'(pn_reg[0]) + tnpd_pkg::NUM_W'(pn_reg[1])
                 + tnpd_pkg::NUM_W'(pn_reg[2]);
    assign den_c = tnpd_pkg::DEN_W'(pd_reg[0][15:0]) + tnpd_pkg::DEN_W'(pd_reg[1][15:0])
                 + tnpd_pkg::DEN_W'(pd_reg[2][15:0]);
    assign num_pos_c = !num_c[tnpd_pkg::NUM_W-1] && (num_c != '0);

    // Restoring divide of num*256 by den, one quotient bit a step.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_sum)
        begin
            num_pos_reg <= num_pos_c;
            sat_reg     <= num_pos_c
                        && ({1'b0, num_c[tnpd_pkg::NUM_W-2:0]} >= {den_c, 1'b0});
            rem_reg     <= num_pos_c ? {1'b0, num_c[tnpd_pkg::NUM_W-2:0], 8'd0} : '0;
            dsh_reg     <= {1'b0, den_c, 8'd0};
            q_reg       <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[tnpd_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                q_reg   <= {q_reg[tnpd_pkg::FRAC_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Clamped fraction and per-phase choice.
    always_comb
    begin
        if (solid_c || !num_pos_reg)
        begin
            t_c = '0;
        end
        else if (sat_reg || (q_reg > 9'd256))
        begin
            t_c = 9'd256;
        end
        else
        begin
            t_c = q_reg;
        end
        for (int p = 0; p < tnpd_pkg::PHASES_MAX; p++)
        begin
            if (!solid_c && (3'(p) < nph) && (t_c > tnpd_pkg::PHASE_THR[nph_row][p]))
            begin
                ph_c[p] = i1_reg;
            end
            else
            begin
                ph_c[p] = i0_reg;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res.nearest     <= tnpd_pkg::OUT_IDX_W'(i0_reg);
            res.second      <= have1_reg ? tnpd_pkg::OUT_IDX_W'(i1_reg) : '0;
            res.has_second  <= have1_reg;
            res.solid       <= solid_c;
            res.fraction    <= t_c;
            res.phase_zero  <= tnpd_pkg::OUT_IDX_W'(ph_c[0]);
            res.phase_one   <= tnpd_pkg::OUT_IDX_W'(ph_c[1]);
            res.phase_two   <= tnpd_pkg::OUT_IDX_W'(ph_c[2]);
            res.phase_three <= tnpd_pkg::OUT_IDX_W'(ph_c[3]);
        end
    end

endmodule

`default_nettype wire

[hdl/two_nearest_palette_dither_mapper.sv]
// Top level of the two-nearest palette dither mapper.
//
//  Channel   Dir  Handshake                 Carries
//  pix_in    in   valid/ready               op, entry_index, red, green, blue
//  map_out   out  valid/ready               nearest, second, has_second, solid,
//                                           fraction, phase_zero..phase_three
//  APB       in   psel/penable, pready=1    active_colors, phase_count, deadband
//
// A palette write word is taken without leaving the idle state, and writes may follow back to back.
// A query occupies the block from accept until its result is loaded: the scan reads
// the palette memory one entry per cycle through its single read port, n being the
// searched entry count, and an answer that is not solid adds a nine-step restoring
// divider. A finished word waits in the output register; the
// sequencer holds in its final state only while that register is still occupied.
// Reset restores the register defaults; palette entries hold no reset value.
`default_nettype none

module two_nearest_palette_dither_mapper #(
    parameter int MAX_COLORS = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    tnpd_in_if.sink           pix_in,
    tnpd_out_if.source        map_out,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output      logic [31:0]  prdata,
    output      logic         pready
);

    localparam int IDX_W = $clog2(MAX_COLORS);

    tnpd_pkg::cfg_t  cfg;
    tnpd_pkg::cmd_t  cmd;
    tnpd_pkg::stat_t stat;
    tnpd_pkg::res_t  res;
    logic [IDX_W-1:0] scan_addr;
    logic             in_ready;
    logic             out_valid;

    tnpd_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tnpd_ctrl #(
        .MAX_COLORS (MAX_COLORS)
    ) u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pix_in.valid),
        .in_op         (pix_in.op),
        .out_ready     (map_out.ready),
        .active_colors (cfg.active_colors),
        .stat          (stat),
        .cmd           (cmd),
        .scan_addr     (scan_addr),
        .in_ready      (in_ready),
        .out_valid     (out_valid)
    );

    tnpd_datapath #(
        .MAX_COLORS (MAX_COLORS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .scan_addr   (scan_addr),
        .entry_index (pix_in.entry_index),
        .red         (pix_in.red),
        .green       (pix_in.green),
        .blue        (pix_in.blue),
        .cfg         (cfg),
        .stat        (stat),
        .res         (res)
    );

    // Channel wiring.
    assign pix_in.ready        = in_ready;
    assign map_out.valid       = out_valid;
    assign map_out.nearest     = res.nearest;
    assign map_out.second      = res.second;
    assign map_out.has_second  = res.has_second;
    assign map_out.solid       = res.solid;
    assign map_out.fraction    = res.fraction;
    assign map_out.phase_zero  = res.phase_zero;
    assign map_out.phase_one   = res.phase_one;
    assign map_out.phase_two   = res.phase_two;
    assign map_out.phase_three = res.phase_three;

endmodule

`default_nettype wire

[hdl/tnpd_checker.sv]
// Port-level checks for the palette mapper, bound to its top level.
`default_nettype none

module tnpd_checker
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tnpd_in_if.sink     pix_in,
    tnpd_out_if.source  map_out
);

    // A query word occupies the block, so the input stalls right after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready && pix_in.op) |=> !pix_in.ready)
    else $error("input still ready after a query word");

    // A palette write leaves the block free for the next word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready && !pix_in.op) |=> pix_in.ready)
    else $error("input stalled after a palette write");

    // A new result appears only after the block stopped taking input.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(map_out.valid) |-> $past(!pix_in.ready))
    else $error("result appeared while input was open");

    // A solid result has no blend and every phase on the nearest entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (map_out.valid && map_out.solid) |->
            (map_out.fraction == 9'd0) && (map_out.phase_zero == map_out.nearest)
            && (map_out.phase_one == map_out.nearest)
            && (map_out.phase_two == map_out.nearest)
            && (map_out.phase_three == map_out.nearest))
    else $error("solid result with blended phases");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (map_out.valid && !map_out.ready) |=>
            map_out.valid && $stable(map_out.nearest) && $stable(map_out.fraction)
            && $stable(map_out.phase_zero))
    else $error("stalled result word changed");

endmodule

bind two_nearest_palette_dither_mapper tnpd_checker u_tnpd_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .pix_in  (pix_in),
    .map_out (map_out)
);

`default_nettype wire
